>>> rtl/psd_pkg.sv
package psd_pkg;

    typedef enum logic [3:0] {
        PH_SCAN    = 4'd0,
        PH_PACK    = 4'd1,
        PH_PES_LEN = 4'd2,
        PH_PES_HDR = 4'd3,
        PH_DATA    = 4'd4,
        PH_SKIP    = 4'd5
    } phase_t;

    // header sub-form; meaning depends on the phase
    typedef enum logic [2:0] {
        HK_START   = 3'd0,  // PES: flag byte not seen yet
        HK_ONE     = 3'd1,  // pack: MPEG-1; PES: foreign stream
        HK_TWO     = 3'd2,  // MPEG-2 pack or PES header
        HK_STUFF   = 3'd3,  // MPEG-1 stuffing
        HK_STD     = 3'd4,  // MPEG-1 STD bytes
        HK_PTS     = 3'd5   // MPEG-1 PTS/DTS skip
    } hdr_kind_t;

    typedef enum logic [2:0] {
        EV_PAYLOAD  = 3'd0,
        EV_PROG_END = 3'd1,
        EV_BAD_PACK = 3'd2,
        EV_VIDEO    = 3'd3,
        EV_STUFFING = 3'd4
    } event_t;

    typedef struct packed {
        logic       emit;
        logic [7:0] payload;
        event_t     ev;
    } result_t;

    localparam logic [7:0] ID_PROG_END  = 8'hb9;
    localparam logic [7:0] ID_PACK      = 8'hba;
    localparam logic [8:0] MAX_STUFF    = 9'd23;
    localparam logic [8:0] PACK2_LEN    = 9'd14;
    localparam logic [8:0] PACK1_LEN    = 9'd12;
    localparam logic [8:0] PES2_LEN     = 9'd9;
    localparam logic [8:0] FIRST_POS    = 9'd4;
    localparam logic [23:0] START_PREFIX = 24'h000001;

    function automatic logic [3:0] pts_skip(input logic [3:0] code);
        logic [3:0] r;
        r = 4'd0;
        case (code)
            4'd2:    r = 4'd4;
            4'd3:    r = 4'd9;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/program_stream_demux.sv
// Program stream demultiplexer: one stream byte per input transfer.
// Input channel: data_byte with in_valid / in_stall. Output channel:
// payload_byte and event_res with out_valid / out_stall. A transfer
// happens on a rising edge with valid high and stall low.
// Bytes of PES packets whose stream id matches track_id leave as
// payload (event_res 0); program end, bad pack header, video start
// code and excess stuffing leave as events with payload_byte 0.
// Headers and other streams produce no output.
// A taken byte waits in the input register; the parser result is registered
// in the output register. Throughput: one byte per cycle unless the output
// stalls, set by the combinational parser between the two registers.
// A stalled output holds its result; the input register still takes a
// byte until it is full, then in_stall rises in the same cycle.
// track_id_we writes track_id (write only while idle).
// Reset: track_id returns to 0xE0, parser scans for a start code with
// no prefix bytes remembered, both registers empty.
module program_stream_demux (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       track_id_we,
    input  logic [7:0] track_id,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] payload_byte,
    output logic [2:0] event_res
);
    import psd_pkg::*;

    logic       in_vld;
    logic [7:0] cur_byte;
    logic       out_free;
    logic       fire;
    result_t    res;

    assign fire = in_vld && out_free;

    psd_in_reg u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .fire      (fire),
        .vld       (in_vld),
        .byte_out  (cur_byte)
    );

    psd_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .track_id_we (track_id_we),
        .track_id    (track_id),
        .fire        (fire),
        .b           (cur_byte),
        .res         (res)
    );

    psd_out_reg u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .res          (res),
        .out_free     (out_free),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .payload_byte (payload_byte),
        .event_res    (event_res)
    );

endmodule

>>> rtl/psd_in_reg.sv
module psd_in_reg (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       fire,
    output logic       vld,
    output logic [7:0] byte_out
);
    import psd_pkg::*;

    logic       vld_reg, vld_next;
    logic [7:0] byte_reg;

    assign in_stall = vld_reg && !fire;
    assign vld      = vld_reg;
    assign byte_out = byte_reg;

    always_comb
    begin
        if (in_valid && !in_stall)
        begin
            vld_next = 1'b1;
        end
        else if (fire)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= data_byte;
        end
    end

endmodule

>>> rtl/psd_core.sv
module psd_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             track_id_we,
    input  logic [7:0]       track_id,
    input  logic             fire,
    input  logic [7:0]       b,
    output psd_pkg::result_t res
);
    import psd_pkg::*;

    logic [7:0]  track_reg;
    logic [23:0] recent_reg, recent_next;
    phase_t      phase_reg, phase_next;
    logic [8:0]  hpos_reg, hpos_next;
    logic [8:0]  hlen_reg, hlen_next;
    logic [15:0] plen_reg, plen_next;
    hdr_kind_t   kind_reg, kind_next;
    logic [16:0] remain_reg, remain_next;

    logic [8:0]  pos1;
    logic [8:0]  hl_v;
    hdr_kind_t   kind_v;
    hdr_kind_t   tf_kind;
    logic [8:0]  tf_hl;
    logic [15:0] plen_v;
    logic [17:0] count;
    logic        bad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_reg <= 8'he0;
        end
        else if (track_id_we)
        begin
            track_reg <= track_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_reg <= 24'hffffff;
            phase_reg  <= PH_SCAN;
            hpos_reg   <= 9'd0;
            hlen_reg   <= 9'd0;
            plen_reg   <= 16'd0;
            kind_reg   <= HK_START;
            remain_reg <= 17'd0;
        end
        else if (fire)
        begin
            recent_reg <= recent_next;
            phase_reg  <= phase_next;
            hpos_reg   <= hpos_next;
            hlen_reg   <= hlen_next;
            plen_reg   <= plen_next;
            kind_reg   <= kind_next;
            remain_reg <= remain_next;
        end
    end

    // MPEG-1 flag byte: STD marker or PTS/DTS code
    always_comb
    begin
        if (b[7:6] == 2'b01)
        begin
            tf_kind = HK_STD;
            tf_hl   = hpos_reg + 9'd3;
        end
        else
        begin
            tf_kind = HK_PTS;
            tf_hl   = hpos_reg + 9'd1 + {5'd0, pts_skip(b[7:4])};
        end
    end

    always_comb
    begin
        recent_next = recent_reg;
        phase_next  = phase_reg;
        hpos_next   = hpos_reg;
        hlen_next   = hlen_reg;
        plen_next   = plen_reg;
        kind_next   = kind_reg;
        remain_next = remain_reg;
        res         = '{emit: 1'b0, payload: 8'd0, ev: EV_PAYLOAD};
        pos1        = hpos_reg + 9'd1;
        hl_v        = hlen_reg;
        kind_v      = kind_reg;
        plen_v      = plen_reg | {8'd0, b};
        count       = 18'd6 + {2'd0, plen_reg} - {9'd0, hlen_reg};
        bad         = 1'b0;

        unique case (phase_reg)
            PH_SCAN:
            begin
                if (recent_reg == START_PREFIX)
                begin
                    recent_next = 24'hffffff;
                    hpos_next   = FIRST_POS;
                    hlen_next   = 9'd0;
                    kind_next   = HK_START;
                    plen_next   = 16'd0;
                    if (b == ID_PROG_END)
                    begin
                        res.emit = 1'b1;
                        res.ev   = EV_PROG_END;
                    end
                    else if (b == ID_PACK)
                    begin
                        phase_next = PH_PACK;
                    end
                    else if (b == track_reg)
                    begin
                        phase_next = PH_PES_LEN;
                    end
                    else if (b < ID_PROG_END)
                    begin
                        res.emit = 1'b1;
                        res.ev   = EV_VIDEO;
                    end
                    else
                    begin
                        phase_next = PH_PES_LEN;
                        kind_next  = HK_ONE;
                    end
                end
                else
                begin
                    recent_next = {recent_reg[15:0], b};
                end
            end
            PH_PACK:
            begin
                hpos_next = pos1;
                if (hpos_reg == FIRST_POS)
                begin
                    if (b[7:6] == 2'b01)
                    begin
                        kind_v = HK_TWO;
                        hl_v   = PACK2_LEN;
                    end
                    else if (b[7:4] == 4'h2)
                    begin
                        kind_v = HK_ONE;
                        hl_v   = PACK1_LEN;
                    end
                    else
                    begin
                        bad = 1'b1;
                    end
                end
                else if (kind_reg == HK_TWO && hpos_reg == 9'd13)
                begin
                    // pack stuffing length in low bits of byte 13
                    hl_v = PACK2_LEN + {6'd0, b[2:0]};
                end
                if (bad)
                begin
                    res.emit   = 1'b1;
                    res.ev     = EV_BAD_PACK;
                    phase_next = PH_SCAN;
                end
                else
                begin
                    kind_next = kind_v;
                    hlen_next = hl_v;
                    if (pos1 >= hl_v)
                    begin
                        phase_next = PH_SCAN;
                    end
                end
            end
            PH_PES_LEN:
            begin
                hpos_next = pos1;
                if (hpos_reg == FIRST_POS)
                begin
                    plen_next = {b, 8'd0};
                end
                else
                begin
                    plen_next = plen_v;
                    if (kind_reg == HK_ONE)
                    begin
                        if (plen_v == 16'd0)
                        begin
                            phase_next = PH_SCAN;
                        end
                        else
                        begin
                            remain_next = {1'b0, plen_v};
                            phase_next  = PH_SKIP;
                        end
                    end
                    else
                    begin
                        kind_next  = HK_START;
                        phase_next = PH_PES_HDR;
                    end
                end
            end
            PH_PES_HDR:
            begin
                hpos_next = pos1;
                case (kind_reg)
                    HK_START:
                    begin
                        if (b[7:6] == 2'b10)
                        begin
                            kind_v = HK_TWO;
                            hl_v   = PES2_LEN;
                        end
                        else if (b == 8'hff)
                        begin
                            kind_v = HK_STUFF;
                        end
                        else
                        begin
                            kind_v = tf_kind;
                            hl_v   = tf_hl;
                        end
                    end
                    HK_TWO:
                    begin
                        if (hpos_reg == 9'd8)
                        begin
                            hl_v = PES2_LEN + {1'b0, b};
                        end
                    end
                    HK_STUFF:
                    begin
                        // stuffing cap reached: this byte is the flag byte regardless
                        if (hpos_reg >= MAX_STUFF)
                        begin
                            res.emit = 1'b1;
                            res.ev   = EV_STUFFING;
                            kind_v   = tf_kind;
                            hl_v     = tf_hl;
                        end
                        else if (b != 8'hff)
                        begin
                            kind_v = tf_kind;
                            hl_v   = tf_hl;
                        end
                    end
                    HK_STD:
                    begin
                        if (pos1 >= hlen_reg)
                        begin
                            kind_v = HK_PTS;
                            hl_v   = hlen_reg + {5'd0, pts_skip(b[7:4])};
                        end
                    end
                    default:
                    begin
                        kind_v = kind_reg;
                    end
                endcase
                kind_next = kind_v;
                hlen_next = hl_v;
                count     = 18'd6 + {2'd0, plen_reg} - {9'd0, hl_v};
                if ((kind_v == HK_TWO || kind_v == HK_PTS) && pos1 >= hl_v)
                begin
                    if (!count[17] && count != 18'd0)
                    begin
                        remain_next = count[16:0];
                        phase_next  = PH_DATA;
                    end
                    else
                    begin
                        phase_next = PH_SCAN;
                    end
                end
            end
            PH_DATA:
            begin
                res.emit    = 1'b1;
                res.payload = b;
                res.ev      = EV_PAYLOAD;
                if (remain_reg <= 17'd1)
                begin
                    remain_next = 17'd0;
                    phase_next  = PH_SCAN;
                end
                else
                begin
                    remain_next = remain_reg - 17'd1;
                end
            end
            PH_SKIP:
            begin
                if (remain_reg <= 17'd1)
                begin
                    remain_next = 17'd0;
                    phase_next  = PH_SCAN;
                end
                else
                begin
                    remain_next = remain_reg - 17'd1;
                end
            end
            default:
            begin
                phase_next = PH_SCAN;
            end
        endcase
    end

    a_data_emits: assert property (@(posedge clk) disable iff (!rst_n)
        fire && phase_reg == PH_DATA |-> res.emit && res.ev == EV_PAYLOAD && res.payload == b)
        else $error("payload byte not emitted in data phase");

    a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA || phase_reg == PH_SKIP) |-> remain_reg != 17'd0)
        else $error("data or skip phase with empty count");

    a_event_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res.emit && res.ev != EV_PAYLOAD |-> res.payload == 8'd0)
        else $error("event result carries payload");

    a_scan_leave: assert property (@(posedge clk) disable iff (!rst_n)
        fire && phase_reg == PH_SCAN && recent_reg != START_PREFIX |=> phase_reg == PH_SCAN)
        else $error("left scanning without start code");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hpos_reg <= 9'd266)
        else $error("header position out of range");

endmodule

>>> rtl/psd_out_reg.sv
module psd_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  psd_pkg::result_t res,
    output logic             out_free,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       payload_byte,
    output logic [2:0]       event_res
);
    import psd_pkg::*;

    logic       vld_reg, vld_next;
    logic [7:0] pay_reg;
    event_t     ev_reg;

    assign out_free     = !vld_reg || !out_stall;
    assign out_valid    = vld_reg;
    assign payload_byte = pay_reg;
    assign event_res    = ev_reg;

    always_comb
    begin
        if (fire)
        begin
            vld_next = res.emit;
        end
        else if (out_stall)
        begin
            vld_next = vld_reg;
        end
        else
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res.emit)
        begin
            pay_reg <= res.payload;
            ev_reg  <= res.ev;
        end
    end

endmodule
